// ----- hdl/stk_pkg.sv -----
// shared types and constants for the bounded stack with listing
// used by stk_front, stk_back, bounded_stack_with_listing and the testbench
package stk_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH   = 4;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 7;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;

    // input data is push_value then list_count, padded to whole bytes
    localparam int S_DATA_W = ((WORD_W + CNT_W + 7) / 8) * 8;
    // result data is data then reached_bottom, padded to whole bytes
    localparam int M_DATA_W = ((WORD_W + 1 + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_LIST = 2'd2
    } stk_cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_POP      = 2'd0,
        KIND_LIST     = 2'd1,
        KIND_OVERFLOW = 2'd2,
        KIND_EMPTY    = 2'd3
    } stk_kind_t;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_POP      = 3'd1,
        OP_LIST     = 3'd2,
        OP_OVERFLOW = 3'd3,
        OP_EMPTY    = 3'd4
    } stk_op_t;

    typedef struct packed {
        stk_op_t op;
        logic    bottom;
    } stk_ctl_t;

endpackage

// ----- hdl/stk_front.sv -----
// front end: accepts items, tracks stack height and capacity, turns each push,
// pop or list command into a queued operation for the back end; uses stk_pkg
module stk_front #(
    parameter int DEPTH = stk_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int HW    = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [stk_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [stk_pkg::CMD_W-1:0]    in_cmd,
    input  logic [stk_pkg::WORD_W-1:0]   in_value,
    input  logic [stk_pkg::CNT_W-1:0]    in_count,
    output logic                         q_wr_en,
    input  logic                         q_wr_ready,
    output stk_pkg::stk_ctl_t            q_ctl,
    output logic [AW-1:0]                q_addr,
    output logic [HW-1:0]                q_count,
    output logic [stk_pkg::WORD_W-1:0]   q_value
);

    localparam int CW = (HW > stk_pkg::CAP_W) ? HW : stk_pkg::CAP_W;

    logic [stk_pkg::CAP_W-1:0] capacity_reg;
    logic [HW-1:0]             height_reg, height_next;
    logic [CW-1:0]             cap_w, dep_w, cap_eff, h_w, cnt_w;
    logic                      accept, full, empty, enq;

    assign in_ready = q_wr_ready;
    assign accept   = in_valid && in_ready;

    assign cap_w   = CW'(capacity_reg);
    assign dep_w   = CW'(DEPTH);
    assign cap_eff = (cap_w < dep_w) ? cap_w : dep_w;
    assign h_w     = CW'(height_reg);
    assign cnt_w   = CW'(in_count);
    assign full    = (h_w >= cap_eff);
    assign empty   = (height_reg == '0);

    always_comb begin
        enq         = 1'b0;
        height_next = height_reg;
        q_ctl.op    = stk_pkg::OP_EMPTY;
        q_ctl.bottom = 1'b0;
        q_addr      = height_reg[AW-1:0] - AW'(1);
        q_count     = HW'(1);
        q_value     = in_value;
        unique case (stk_pkg::stk_cmd_t'(in_cmd))
            stk_pkg::CMD_PUSH: begin
                enq = 1'b1;
                if (full) begin
                    q_ctl.op = stk_pkg::OP_OVERFLOW;
                end else begin
                    q_ctl.op    = stk_pkg::OP_WRITE;
                    q_addr      = height_reg[AW-1:0];
                    height_next = height_reg + HW'(1);
                end
            end
            stk_pkg::CMD_POP: begin
                enq = 1'b1;
                if (!empty) begin
                    q_ctl.op    = stk_pkg::OP_POP;
                    height_next = height_reg - HW'(1);
                end
            end
            stk_pkg::CMD_LIST: begin
                enq = 1'b1;
                if (!empty) begin
                    q_ctl.op = stk_pkg::OP_LIST;
                    priority if (cnt_w == '0) begin
                        q_count = height_reg;
                    end else if (cnt_w >= h_w) begin
                        q_count      = height_reg;
                        q_ctl.bottom = 1'b1;
                    end else begin
                        q_count = cnt_w[HW-1:0];
                    end
                end
            end
            default: begin
                // unused command code is dropped
                enq = 1'b0;
            end
        endcase
    end

    assign q_wr_en = accept && enq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= stk_pkg::CAP_RESET;
            height_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (q_wr_en) begin
                height_reg <= height_next;
            end
        end
    end

endmodule

// ----- hdl/stk_fifo.sv -----
// short queue of operations between front end and back end
// generic width, no package dependencies
module stk_fifo #(
    parameter int WIDTH  = 8,
    parameter int QDEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    fill_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (fill_reg != NW'(QDEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + NW'(1);
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

// ----- hdl/stk_back.sv -----
// back end: holds the stack memory, carries out queued operations and
// drives the result register; uses stk_pkg
module stk_back #(
    parameter int DEPTH = stk_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int HW    = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_rd_en,
    input  stk_pkg::stk_ctl_t             q_ctl,
    input  logic [AW-1:0]                 q_addr,
    input  logic [HW-1:0]                 q_count,
    input  logic [stk_pkg::WORD_W-1:0]    q_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stk_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [stk_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                        state_reg;
    logic [stk_pkg::WORD_W-1:0]    mem [DEPTH];
    logic [stk_pkg::WORD_W-1:0]    rd_data_reg;
    logic [AW-1:0]                 rd_addr, cur_addr_reg;
    logic [HW-1:0]                 remain_reg;
    stk_pkg::stk_kind_t            kind_reg;
    logic                          bottom_reg;
    logic                          rd_en, wr_en, out_free, load, final_one;

    logic                          m_tvalid_reg, m_tlast_reg;
    logic [stk_pkg::M_DATA_W-1:0]  m_tdata_reg;
    logic [stk_pkg::KIND_W-1:0]    m_tuser_reg;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign final_one = (remain_reg == HW'(1));

    always_comb begin
        q_rd_en = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        load    = 1'b0;
        rd_addr = q_addr;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_ctl.op)
                        stk_pkg::OP_WRITE: begin
                            wr_en   = 1'b1;
                            q_rd_en = 1'b1;
                        end
                        stk_pkg::OP_POP, stk_pkg::OP_LIST: begin
                            rd_en   = 1'b1;
                            q_rd_en = 1'b1;
                        end
                        default: begin
                            // overflow and empty reports go straight out
                            load    = out_free;
                            q_rd_en = out_free;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                load    = out_free;
                // fetch the next entry down while this one goes out
                rd_addr = cur_addr_reg - AW'(1);
                rd_en   = out_free && !final_one;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[q_addr] <= q_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (rd_en) begin
                        cur_addr_reg <= q_addr;
                        remain_reg   <= q_count;
                        bottom_reg   <= q_ctl.bottom;
                        kind_reg     <= (q_ctl.op == stk_pkg::OP_LIST) ?
                                        stk_pkg::KIND_LIST : stk_pkg::KIND_POP;
                        state_reg    <= ST_EMIT;
                    end
                    if (load) begin
                        m_tdata_reg <= '0;
                        m_tuser_reg <= (q_ctl.op == stk_pkg::OP_OVERFLOW) ?
                                       stk_pkg::KIND_OVERFLOW : stk_pkg::KIND_EMPTY;
                        m_tlast_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (load) begin
                        m_tdata_reg <= {{(stk_pkg::M_DATA_W - stk_pkg::WORD_W - 1){1'b0}},
                                        bottom_reg && final_one, rd_data_reg};
                        m_tuser_reg <= kind_reg;
                        m_tlast_reg <= final_one;
                        if (final_one) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cur_addr_reg <= rd_addr;
                            remain_reg   <= remain_reg - HW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hdl/bounded_stack_with_listing.sv -----
// a pop or list result passes through the operation queue, the stack memory read
//   register and the result register before it shows on m_; an overflow or empty
//   report passes through the queue and the result register only; the back end
//   finishes each operation before it takes the next, paced by the back-end
//   sequencer and the single read port of the stack memory
// reset: height cleared, capacity back to 64, queue and result register
//   emptied; stack memory contents are left as they are
module bounded_stack_with_listing #(
    parameter int DEPTH  = stk_pkg::DEPTH_DEFAULT,
    parameter int QDEPTH = stk_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [stk_pkg::CAP_W-1:0]     cfg_wr_data,    // capacity
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stk_pkg::S_DATA_W-1:0]  s_tdata,        // push_value, list_count
    input  logic [stk_pkg::CMD_W-1:0]     s_tuser,        // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stk_pkg::M_DATA_W-1:0]  m_tdata,        // data, reached_bottom
    output logic [stk_pkg::KIND_W-1:0]    m_tuser,        // kind
    output logic                          m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int QW = $bits(stk_pkg::stk_ctl_t) + AW + HW + stk_pkg::WORD_W;

    stk_pkg::stk_ctl_t           f_ctl, b_ctl;
    logic [AW-1:0]               f_addr, b_addr;
    logic [HW-1:0]               f_count, b_count;
    logic [stk_pkg::WORD_W-1:0]  f_value, b_value;
    logic [QW-1:0]               q_wr_data, q_rd_data;
    logic                        q_wr_en, q_wr_ready, q_valid, q_rd_en;

    stk_front #(.DEPTH(DEPTH), .AW(AW), .HW(HW)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_value   (s_tdata[stk_pkg::WORD_W-1:0]),
        .in_count   (s_tdata[stk_pkg::WORD_W +: stk_pkg::CNT_W]),
        .q_wr_en    (q_wr_en),
        .q_wr_ready (q_wr_ready),
        .q_ctl      (f_ctl),
        .q_addr     (f_addr),
        .q_count    (f_count),
        .q_value    (f_value)
    );

    assign q_wr_data = {f_ctl, f_addr, f_count, f_value};

    stk_fifo #(.WIDTH(QW), .QDEPTH(QDEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_ready(q_wr_ready),
        .wr_data (q_wr_data),
        .rd_valid(q_valid),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data)
    );

    assign {b_ctl, b_addr, b_count, b_value} = q_rd_data;

    stk_back #(.DEPTH(DEPTH), .AW(AW), .HW(HW)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_rd_en (q_rd_en),
        .q_ctl   (b_ctl),
        .q_addr  (b_addr),
        .q_count (b_count),
        .q_value (b_value),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // reached_bottom only ever rides on the final listed entry
    a_bottom_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[stk_pkg::WORD_W]) |->
            (m_tlast && m_tuser == stk_pkg::KIND_LIST))
        else $error("reached_bottom on a result that is not the last listed entry");

    // every result that is not a listed entry ends its command
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != stk_pkg::KIND_LIST) |-> m_tlast)
        else $error("single-result command without tlast");

    // overflow and empty reports carry zero data
    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == stk_pkg::KIND_OVERFLOW || m_tuser == stk_pkg::KIND_EMPTY))
            |-> (m_tdata[stk_pkg::WORD_W-1:0] == '0))
        else $error("nonzero data on overflow or empty report");

    // a waiting result holds steady until it is taken
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed or dropped while waiting");

endmodule

// ----- dv/bounded_stack_with_listing_test.sv -----
// self-checking testbench for bounded_stack_with_listing: directed and random
// push, pop and list items checked against an in-bench stack predictor
// depends on hdl/stk_pkg.sv and hdl/bounded_stack_with_listing.sv
module bounded_stack_with_listing_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = stk_pkg::DEPTH_DEFAULT;
    localparam int IDLE_GAP       = 2 * stk_pkg::QUEUE_DEPTH + 8;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT    = 1000;
    // command code with no meaning, the block drops it
    localparam logic [stk_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [stk_pkg::CMD_W-1:0]  cmd;
        logic [stk_pkg::WORD_W-1:0] value;
        logic [stk_pkg::CNT_W-1:0]  count;
    } stk_item_t;

    typedef struct packed {
        stk_pkg::stk_kind_t         kind;
        logic [stk_pkg::WORD_W-1:0] data;
        logic                       bottom;
        logic                       last;
    } stk_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [stk_pkg::CAP_W-1:0]    cfg_wr_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [stk_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [stk_pkg::CMD_W-1:0]    s_tuser = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [stk_pkg::M_DATA_W-1:0] m_tdata;
    logic [stk_pkg::KIND_W-1:0]   m_tuser;
    logic                         m_tlast;

    bounded_stack_with_listing u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [stk_pkg::WORD_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned                shadow_height = 0;
    logic [stk_pkg::CAP_W-1:0]  shadow_capacity = stk_pkg::CAP_RESET;
    stk_result_t                expected_results [$];

    stk_item_t pending_items [$];
    stk_item_t offered_item;
    int queued_count  = 0;
    int offered_count = 0;
    int taken_count   = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int rx_hold_id    = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;
    int stall_cycles  = 0;
    int mismatches    = 0;
    bit burst_mode    = 1'b0;

    function automatic void expect_result(stk_pkg::stk_kind_t kind,
                                          logic [stk_pkg::WORD_W-1:0] data,
                                          logic bottom, logic last);
        stk_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.bottom = bottom;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void stack_apply(stk_item_t it);
        int unsigned eff_cap;
        int unsigned n;
        logic        bottom;
        eff_cap = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
        case (it.cmd)
            stk_pkg::CMD_PUSH: begin
                if (shadow_height >= eff_cap) begin
                    expect_result(stk_pkg::KIND_OVERFLOW, '0, 1'b0, 1'b1);
                end else if (shadow_height < STACK_DEPTH) begin
                    shadow_stack[shadow_height] = it.value;
                    shadow_height++;
                end
            end
            stk_pkg::CMD_POP: begin
                if (shadow_height == 0) begin
                    expect_result(stk_pkg::KIND_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    shadow_height--;
                    expect_result(stk_pkg::KIND_POP, shadow_stack[shadow_height],
                                  1'b0, 1'b1);
                end
            end
            stk_pkg::CMD_LIST: begin
                if (shadow_height == 0) begin
                    expect_result(stk_pkg::KIND_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    // count zero lists all without the bottom flag
                    if (it.count == 0) begin
                        n = shadow_height;
                        bottom = 1'b0;
                    end else if (it.count >= shadow_height) begin
                        n = shadow_height;
                        bottom = 1'b1;
                    end else begin
                        n = it.count;
                        bottom = 1'b0;
                    end
                    for (int i = 0; i < n; i++) begin
                        expect_result(stk_pkg::KIND_LIST,
                                      shadow_stack[shadow_height - 1 - i],
                                      (i == n - 1) ? bottom : 1'b0, i == n - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic stk_item_t random_item(int push_pct, int pop_pct);
        stk_item_t it;
        int        r;
        r = $urandom_range(0, 99);
        it.value = $urandom;
        case ($urandom_range(0, 9))
            0:       it.count = '0;
            1, 2, 3: it.count = stk_pkg::CNT_W'($urandom_range(1, 8));
            4, 5, 6: it.count = stk_pkg::CNT_W'($urandom_range(1, STACK_DEPTH));
            default: it.count = stk_pkg::CNT_W'($urandom_range(STACK_DEPTH + 1, 127));
        endcase
        if (r < 3)
            it.cmd = CMD_NONE;
        else if (r < 3 + push_pct)
            it.cmd = stk_pkg::CMD_PUSH;
        else if (r < 3 + push_pct + pop_pct)
            it.cmd = stk_pkg::CMD_POP;
        else
            it.cmd = stk_pkg::CMD_LIST;
        return it;
    endfunction

    task automatic queue_item(logic [stk_pkg::CMD_W-1:0] cmd,
                              logic [stk_pkg::WORD_W-1:0] value,
                              logic [stk_pkg::CNT_W-1:0] count);
        pending_items.push_back({cmd, value, count});
        queued_count++;
    endtask

    // dropped commands do not count toward n
    task automatic queue_random(int n, int push_pct, int pop_pct);
        stk_item_t it;
        int        real_items;
        real_items = 0;
        while (real_items < n) begin
            it = random_item(push_pct, pop_pct);
            pending_items.push_back(it);
            queued_count++;
            if (it.cmd != CMD_NONE) real_items++;
        end
    endtask

    // waits until every queued item is taken and every result is back, then leaves an idle gap
    task automatic run_phase();
        while (taken_count != queued_count || expected_results.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [stk_pkg::CAP_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        shadow_capacity = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // sender
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || taken_count == offered_count)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                offered_item = pending_items.pop_front();
                offered_count++;
                s_tvalid <= 1'b1;
                s_tdata <= {{(stk_pkg::S_DATA_W - stk_pkg::WORD_W - stk_pkg::CNT_W){1'b0}},
                            offered_item.count, offered_item.value};
                s_tuser <= offered_item.cmd;
                tx_gap = burst_mode ? 0 : idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (rx_hold_seen != rx_hold_id) begin
            rx_hold_seen = rx_hold_id;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap = burst_mode ? 0 : idle_len();
        end
    end

    // predictor, result checker and watchdog
    always @(posedge aclk) begin
        stk_result_t        want;
        stk_pkg::stk_kind_t got_kind;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                stack_apply(offered_item);
                taken_count++;
            end
            if (m_tvalid && m_tready) begin
                got_kind = stk_pkg::stk_kind_t'(m_tuser);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected item kind %0d data %h last %b",
                                              m_tuser, m_tdata[stk_pkg::WORD_W-1:0],
                                              m_tlast));
                end else begin
                    want = expected_results.pop_front();
                    if (got_kind != want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata[stk_pkg::WORD_W-1:0] != want.data)
                        report_mismatch($sformatf("data %h, want %h",
                                                  m_tdata[stk_pkg::WORD_W-1:0], want.data));
                    if (m_tdata[stk_pkg::WORD_W] != want.bottom)
                        report_mismatch($sformatf("reached_bottom %b, want %b",
                                                  m_tdata[stk_pkg::WORD_W], want.bottom));
                    if (m_tlast != want.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty stack, word extremes, every listing mode, dropped command
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_LIST, '0, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'h7fff_ffff, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'h8000_0000, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'hffff_ffff, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'h0000_0000, 7'd127);
        queue_item(stk_pkg::CMD_PUSH, 32'h5a5a_5a5a, '0);
        queue_item(stk_pkg::CMD_LIST, '0, '0);
        queue_item(stk_pkg::CMD_LIST, '0, 7'd2);
        queue_item(stk_pkg::CMD_LIST, '0, 7'd5);
        queue_item(stk_pkg::CMD_LIST, 32'ha5a5_a5a5, 7'd127);
        queue_item(CMD_NONE, 32'hffff_ffff, 7'd127);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        run_phase();

        // capacity below the current height: entries stay, pushes overflow
        write_capacity(7'd2);
        queue_item(stk_pkg::CMD_PUSH, 32'h1234_5678, '0);
        queue_item(stk_pkg::CMD_LIST, '0, 7'd64);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'd7, '0);
        queue_item(stk_pkg::CMD_PUSH, 32'd8, '0);
        queue_item(stk_pkg::CMD_LIST, '0, 7'd1);
        run_phase();

        // capacity zero: every push overflows
        write_capacity(7'd0);
        queue_item(stk_pkg::CMD_PUSH, 32'hdead_beef, '0);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        queue_item(stk_pkg::CMD_POP, '0, '0);
        run_phase();

        // capacity above the depth: fill until the store itself is full
        write_capacity(7'd127);
        queue_random(80, 92, 2);
        run_phase();

        // receiver holds off while the sender keeps offering
        write_capacity(7'd5);
        burst_mode = 1'b1;
        rx_hold_id++;
        queue_random(20, 35, 35);
        run_phase();

        burst_mode = 1'b0;
        write_capacity(7'd1);
        queue_random(12, 45, 30);
        run_phase();

        write_capacity(7'd64);
        queue_random(10, 15, 50);
        run_phase();

        burst_mode = 1'b1;
        write_capacity(stk_pkg::CAP_W'($urandom_range(1, STACK_DEPTH)));
        queue_random(8, 40, 30);
        run_phase();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/stk_pkg.sv
hdl/stk_front.sv
hdl/stk_fifo.sv
hdl/stk_back.sv
hdl/bounded_stack_with_listing.sv
dv/bounded_stack_with_listing_test.sv
